// ===== rtl/lzw_hash_compressor_top_assert.svh =====
// Assertion macros shared by the LZW compressor RTL.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef LZW_HASH_COMPRESSOR_TOP_ASSERT_SVH
`define LZW_HASH_COMPRESSOR_TOP_ASSERT_SVH

// ante true at an edge implies cons at the same edge
`define LZW_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lzw assertion failed");

// ante true at an edge implies cons at the next edge
`define LZW_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lzw assertion failed");

`endif

// ===== rtl/lzw_pkg.sv =====
// Shared constants and types for the LZW compressor.
// No dependencies.
`timescale 1ns / 1ps

package lzw_pkg;

    localparam int unsigned HASH_SLOTS = 72817;
    localparam int ADDR_W = $clog2(HASH_SLOTS);

    localparam logic [ADDR_W-1:0] SLOTS_A   = ADDR_W'(HASH_SLOTS);
    localparam logic [ADDR_W-1:0] SLOT_LAST = ADDR_W'(HASH_SLOTS - 1);

    // slot word: used, key (prefix,byte), code
    localparam int SLOT_W = 1 + 24 + 16;

    localparam logic [15:0] CODE_RESET = 16'd256;
    localparam logic [15:0] CODE_TAG   = 16'd258;
    localparam logic [16:0] CODE_FIRST = 17'd259;
    localparam logic [6:0]  RATIO_INIT = 7'd100;

    localparam logic REQ_DATA   = 1'b0;
    localparam logic REQ_FINISH = 1'b1;

    typedef struct packed {
        logic       valid;
        logic       is_finish;
        logic [7:0] data_byte;
    } front_item_t;

    typedef struct packed {
        logic pop;
        logic clearing;
    } eng_stat_t;

    typedef struct packed {
        logic       done;
        logic       over;
        logic [7:0] quot;
    } ratio_res_t;

endpackage

// ===== rtl/lzw_hash_compressor_top.sv =====
// LZW hash compressor, top level: front queue plus compression engine.
// Depends on lzw_pkg, lzw_front, lzw_engine.
//
// Input channel (in_valid/in_ready): req_type 0 carries a data byte, 1 finishes
// the unit and flushes the last prefix code. Output channel (out_valid/out_ready)
// delivers 16-bit codes; last marks the final code caused by one input item.
// A byte passes through the idle step, then a probe and a check step per hash
// probe; a miss adds a miss step and an emit step (the emit repeats when it also
// sends the reset code), and the first byte of a unit goes straight to emit. Once
// all codes are used, each miss also runs the bit-serial ratio divider.
// After reset, and after every finish or reset code, the engine sweeps the hash
// table once, one slot a cycle, while in_ready stays low.
// A two-entry input queue keeps taking items while the engine works; when the
// receiver stalls, the output register holds its code and the engine waits in
// its emit step, so the queue fills and then drops in_ready.
`timescale 1ns / 1ps

module lzw_hash_compressor_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        req_type,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] code,
    output logic        last
);

    lzw_pkg::front_item_t item;
    lzw_pkg::eng_stat_t   stat;

    lzw_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .req_type  (req_type),
        .data_byte (data_byte),
        .stat      (stat),
        .item      (item)
    );

    lzw_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .stat      (stat),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .code      (code),
        .last      (last)
    );

endmodule

// ===== rtl/lzw_ram.sv =====
// Generic single-port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps

module lzw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// ===== rtl/lzw_ratio.sv =====
// Ratio unit: floor(out*100/in), restoring division one quotient bit a cycle.
// Depends on lzw_pkg.
`timescale 1ns / 1ps

module lzw_ratio (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [47:0]         num_out,
    input  logic [47:0]         den_in,
    output lzw_pkg::ratio_res_t res
);

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_CHK  = 2'd1;
    localparam logic [1:0] PH_STEP = 2'd2;

    logic [1:0]  ph_reg, ph_next;
    logic [55:0] rem_reg, rem_next;
    logic [47:0] den_reg, den_next;
    logic [2:0]  bit_reg, bit_next;
    logic [7:0]  quot_reg, quot_next;
    logic        over_reg, over_next;
    logic        done_reg, done_next;

    logic [54:0] num_ext;
    logic [54:0] prod;
    logic [55:0] den_sh;

    // times 100 as 64 + 32 + 4
    assign num_ext = {7'b0, num_out};
    assign prod    = (num_ext << 6) + (num_ext << 5) + (num_ext << 2);
    assign den_sh  = {8'b0, den_reg} << bit_reg;

    always_comb
    begin
        ph_next   = ph_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        bit_next  = bit_reg;
        quot_next = quot_reg;
        over_next = over_reg;
        done_next = 1'b0;
        unique case (ph_reg)
            PH_IDLE:
            begin
                if (start)
                begin
                    rem_next  = {1'b0, prod};
                    den_next  = den_in;
                    quot_next = '0;
                    over_next = 1'b0;
                    ph_next   = PH_CHK;
                end
            end
            PH_CHK:
            begin
                // quotient of 256 or more is always worse
                if (rem_reg >= {den_reg, 8'b0})
                begin
                    over_next = 1'b1;
                    done_next = 1'b1;
                    ph_next   = PH_IDLE;
                end
                else
                begin
                    bit_next = 3'd7;
                    ph_next  = PH_STEP;
                end
            end
            PH_STEP:
            begin
                if (rem_reg >= den_sh)
                begin
                    rem_next           = rem_reg - den_sh;
                    quot_next[bit_reg] = 1'b1;
                end
                if (bit_reg == 3'd0)
                begin
                    done_next = 1'b1;
                    ph_next   = PH_IDLE;
                end
                else
                begin
                    bit_next = bit_reg - 3'd1;
                end
            end
            default:
            begin
                ph_next = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ph_reg   <= PH_IDLE;
            done_reg <= 1'b0;
        end
        else
        begin
            ph_reg   <= ph_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        bit_reg  <= bit_next;
        quot_reg <= quot_next;
        over_reg <= over_next;
    end

    assign res.done = done_reg;
    assign res.over = over_reg;
    assign res.quot = quot_reg;

endmodule

// ===== rtl/lzw_front.sv =====
// Front end: accepts input items into a two-entry queue and tags finish requests.
// Depends on lzw_pkg.
`timescale 1ns / 1ps

module lzw_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 req_type,
    input  logic [7:0]           data_byte,
    input  lzw_pkg::eng_stat_t   stat,
    output lzw_pkg::front_item_t item
);

    logic       fin_reg  [2];
    logic [7:0] byte_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push;
    logic       pop;

    assign in_ready = (cnt_reg != 2'd2) && !stat.clearing;
    assign push     = in_valid && in_ready;
    assign pop      = stat.pop && (cnt_reg != 2'd0);

    assign item.valid     = (cnt_reg != 2'd0);
    assign item.is_finish = fin_reg[rd_ptr_reg];
    assign item.data_byte = byte_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fin_reg[wr_ptr_reg]  <= (req_type == lzw_pkg::REQ_FINISH);
            byte_reg[wr_ptr_reg] <= data_byte;
        end
    end

endmodule

// ===== rtl/lzw_engine.sv =====
// Back end: hash probing, code assignment, ratio check, table clears, output register.
// Depends on lzw_pkg, lzw_ram, lzw_ratio and the assertion macro header.
`timescale 1ns / 1ps
`include "lzw_hash_compressor_top_assert.svh"

module lzw_engine (
    input  logic                 clk,
    input  logic                 rst_n,
    input  lzw_pkg::front_item_t item,
    output lzw_pkg::eng_stat_t   stat,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [15:0]          code,
    output logic                 last
);

    localparam int AW = lzw_pkg::ADDR_W;

    localparam logic [3:0] S_CLEAR  = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_PROBE  = 4'd2;
    localparam logic [3:0] S_CHECK  = 4'd3;
    localparam logic [3:0] S_MISS   = 4'd4;
    localparam logic [3:0] S_RSTART = 4'd5;
    localparam logic [3:0] S_RATIO  = 4'd6;
    localparam logic [3:0] S_EMIT   = 4'd7;

    logic [3:0]    state_reg, state_next;
    logic [AW-1:0] clr_addr_reg, clr_addr_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic [AW-1:0] off_reg, off_next;
    logic [AW-1:0] back_reg, back_next;
    logic [AW-1:0] probes_reg, probes_next;
    logic [7:0]    byte_reg, byte_next;
    logic [15:0]   prefix_reg, prefix_next;
    logic [16:0]   next_free_reg, next_free_next;
    logic          started_reg, started_next;
    logic [47:0]   in_cnt_reg, in_cnt_next;
    logic [47:0]   out_cnt_reg, out_cnt_next;
    logic [6:0]    prev_reg, prev_next;
    logic [15:0]   em_code_reg, em_code_next;
    logic          em_two_reg, em_two_next;
    logic [3:0]    after_reg, after_next;
    logic          out_valid_reg, out_valid_next;
    logic [15:0]   code_reg, code_next;
    logic          last_reg, last_next;

    logic                       pop_req;
    logic                       ram_we;
    logic [AW-1:0]              ram_addr;
    logic [lzw_pkg::SLOT_W-1:0] ram_wdata;
    logic [lzw_pkg::SLOT_W-1:0] ram_rdata;
    logic [15:0]                hash;
    logic [AW:0]                step_sum;
    logic [AW-1:0]              idx_step;
    logic                       out_free;
    logic                       ratio_start;
    logic                       worse;
    lzw_pkg::ratio_res_t        ratio;

    lzw_ram #(
        .WIDTH (lzw_pkg::SLOT_W),
        .DEPTH (lzw_pkg::HASH_SLOTS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    lzw_ratio u_ratio (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (ratio_start),
        .num_out (out_cnt_reg),
        .den_in  (in_cnt_reg),
        .res     (ratio)
    );

    assign hash        = prefix_reg ^ {item.data_byte, 8'b0};
    assign step_sum    = {1'b0, idx_reg} + {1'b0, back_reg};
    // secondary probe walks backward by off, wrapping at the table size
    assign idx_step    = (idx_reg < off_reg) ? step_sum[AW-1:0] : idx_reg - off_reg;
    assign out_free    = !out_valid_reg || out_ready;
    assign ratio_start = (state_reg == S_RSTART);
    assign worse       = ratio.over || (ratio.quot > {1'b0, prev_reg});

    always_comb
    begin
        state_next     = state_reg;
        clr_addr_next  = clr_addr_reg;
        idx_next       = idx_reg;
        off_next       = off_reg;
        back_next      = back_reg;
        probes_next    = probes_reg;
        byte_next      = byte_reg;
        prefix_next    = prefix_reg;
        next_free_next = next_free_reg;
        started_next   = started_reg;
        in_cnt_next    = in_cnt_reg;
        out_cnt_next   = out_cnt_reg;
        prev_next      = prev_reg;
        em_code_next   = em_code_reg;
        em_two_next    = em_two_reg;
        after_next     = after_reg;
        out_valid_next = out_valid_reg && !out_ready;
        code_next      = code_reg;
        last_next      = last_reg;
        pop_req        = 1'b0;
        ram_we         = 1'b0;
        ram_addr       = idx_reg;
        ram_wdata      = {1'b1, prefix_reg, byte_reg, next_free_reg[15:0]};

        unique case (state_reg)
            S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_addr  = clr_addr_reg;
                ram_wdata = '0;
                if (clr_addr_reg == lzw_pkg::SLOT_LAST)
                begin
                    clr_addr_next = '0;
                    state_next    = S_IDLE;
                end
                else
                begin
                    clr_addr_next = clr_addr_reg + 1'b1;
                end
            end
            S_IDLE:
            begin
                if (item.valid)
                begin
                    pop_req = 1'b1;
                    if (item.is_finish)
                    begin
                        started_next = 1'b0;
                        if (started_reg)
                        begin
                            em_code_next = prefix_reg;
                            em_two_next  = 1'b0;
                            after_next   = S_CLEAR;
                            state_next   = S_EMIT;
                        end
                        else
                        begin
                            state_next = S_CLEAR;
                        end
                    end
                    else if (!started_reg)
                    begin
                        started_next   = 1'b1;
                        next_free_next = lzw_pkg::CODE_FIRST;
                        prev_next      = lzw_pkg::RATIO_INIT;
                        in_cnt_next    = 48'd1;
                        out_cnt_next   = '0;
                        prefix_next    = {8'b0, item.data_byte};
                        em_code_next   = lzw_pkg::CODE_TAG;
                        em_two_next    = 1'b0;
                        after_next     = S_IDLE;
                        state_next     = S_EMIT;
                    end
                    else
                    begin
                        in_cnt_next = in_cnt_reg + 48'd1;
                        byte_next   = item.data_byte;
                        idx_next    = {{(AW-16){1'b0}}, hash};
                        if (hash == 16'd0)
                        begin
                            off_next  = AW'(1);
                            back_next = lzw_pkg::SLOT_LAST;
                        end
                        else
                        begin
                            off_next  = lzw_pkg::SLOTS_A - {{(AW-16){1'b0}}, hash};
                            back_next = {{(AW-16){1'b0}}, hash};
                        end
                        probes_next = '0;
                        state_next  = S_PROBE;
                    end
                end
            end
            S_PROBE:
            begin
                // read of slot idx issued here, data seen in S_CHECK
                if (probes_reg >= lzw_pkg::SLOTS_A)
                begin
                    state_next = S_MISS;
                end
                else
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (!ram_rdata[lzw_pkg::SLOT_W-1])
                begin
                    if (!next_free_reg[16])
                    begin
                        ram_we         = 1'b1;
                        next_free_next = next_free_reg + 17'd1;
                    end
                    state_next = S_MISS;
                end
                else if (ram_rdata[39:16] == {prefix_reg, byte_reg})
                begin
                    prefix_next = ram_rdata[15:0];
                    state_next  = S_IDLE;
                end
                else
                begin
                    idx_next    = idx_step;
                    probes_next = probes_reg + 1'b1;
                    state_next  = S_PROBE;
                end
            end
            S_MISS:
            begin
                em_code_next = prefix_reg;
                out_cnt_next = out_cnt_reg + 48'd2;
                prefix_next  = {8'b0, byte_reg};
                em_two_next  = 1'b0;
                after_next   = S_IDLE;
                if (next_free_reg[16])
                begin
                    if (in_cnt_reg == 48'd0)
                    begin
                        em_two_next    = 1'b1;
                        after_next     = S_CLEAR;
                        next_free_next = lzw_pkg::CODE_FIRST;
                        in_cnt_next    = '0;
                        out_cnt_next   = '0;
                        prev_next      = lzw_pkg::RATIO_INIT;
                        state_next     = S_EMIT;
                    end
                    else
                    begin
                        state_next = S_RSTART;
                    end
                end
                else
                begin
                    state_next = S_EMIT;
                end
            end
            S_RSTART:
            begin
                state_next = S_RATIO;
            end
            S_RATIO:
            begin
                if (ratio.done)
                begin
                    if (worse)
                    begin
                        em_two_next    = 1'b1;
                        after_next     = S_CLEAR;
                        next_free_next = lzw_pkg::CODE_FIRST;
                        in_cnt_next    = '0;
                        out_cnt_next   = '0;
                        prev_next      = lzw_pkg::RATIO_INIT;
                    end
                    else
                    begin
                        prev_next = ratio.quot[6:0];
                    end
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    code_next      = em_code_reg;
                    last_next      = !em_two_reg;
                    if (em_two_reg)
                    begin
                        em_two_next  = 1'b0;
                        em_code_next = lzw_pkg::CODE_RESET;
                    end
                    else
                    begin
                        state_next = after_reg;
                    end
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    assign stat.pop      = pop_req;
    assign stat.clearing = (state_reg == S_CLEAR);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_addr_reg  <= '0;
            prefix_reg    <= '0;
            next_free_reg <= lzw_pkg::CODE_FIRST;
            started_reg   <= 1'b0;
            in_cnt_reg    <= '0;
            out_cnt_reg   <= '0;
            prev_reg      <= lzw_pkg::RATIO_INIT;
            em_two_reg    <= 1'b0;
            after_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            prefix_reg    <= prefix_next;
            next_free_reg <= next_free_next;
            started_reg   <= started_next;
            in_cnt_reg    <= in_cnt_next;
            out_cnt_reg   <= out_cnt_next;
            prev_reg      <= prev_next;
            em_two_reg    <= em_two_next;
            after_reg     <= after_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg     <= idx_next;
        off_reg     <= off_next;
        back_reg    <= back_next;
        probes_reg  <= probes_next;
        byte_reg    <= byte_next;
        em_code_reg <= em_code_next;
        code_reg    <= code_next;
        last_reg    <= last_next;
    end

    assign out_valid = out_valid_reg;
    assign code      = code_reg;
    assign last      = last_reg;

    `LZW_ASSERT_IMP(a_free_code_cap, 1'b1, next_free_reg <= 17'd65536)
    `LZW_ASSERT_IMP(a_check_follows_probe, state_reg == S_CHECK, $past(state_reg) == S_PROBE)
    `LZW_ASSERT_IMP(a_ratio_done_in_wait, ratio.done, state_reg == S_RATIO)
    `LZW_ASSERT_NXT(a_probe_needs_unit, state_reg == S_PROBE, started_reg)

endmodule
